// ----- src/assert_macros.svh -----
// Assertion macros shared by the hash table RTL.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lpht_pkg.sv -----
// Package for the linear probe hash table: item types, codes and table constants.
// Used by lpht_hash and the top level; depends on nothing.
package lpht_pkg;

  localparam int unsigned CAPACITY   = 1024;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned MARK_W     = 2;
  // Smallest count at which a new key is refused (count*4 >= CAPACITY*3).
  localparam int unsigned FULL_LIMIT = (CAPACITY * 3 + 3) / 4;
  localparam logic [KEY_W-1:0] HASH_MUL = 64'h9e3779b97f4a7c15;

  typedef enum logic [1:0] {
    FN_SET    = 2'd0,
    FN_GET    = 2'd1,
    FN_REMOVE = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MK_EMPTY   = 2'd0,
    MK_USED    = 2'd1,
    MK_DELETED = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE
  } state_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] value_out;
  } rsp_t;

endpackage

// ----- src/lpht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lpht_hash.sv -----
// Home slot computation: low index bits of key times the golden-ratio constant.
// Depends on lpht_pkg for the index width and the multiplier.
module lpht_hash
  import lpht_pkg::*;
(
  input  logic [IDX_W-1:0] key_lo_i,
  output logic [IDX_W-1:0] home_o
);

  // Low bits of a product depend only on the low bits of both factors.
  logic [2*IDX_W-1:0] prod;

  assign prod   = key_lo_i * HASH_MUL[IDX_W-1:0];
  assign home_o = prod[IDX_W-1:0];

endmodule

// ----- src/linear_probe_hash_table.sv -----
// Linear probe hash table, top level: probe sequencer, entry count and result register.
// Depends on lpht_pkg, lpht_hash, lpht_ram and assert_macros.svh.
//
// Usage:
// - Input channel in_valid_i / in_stall_o / in_data_i carries one request item
//   (set, get or remove with key and value). The block takes one item at a time.
// - Output channel out_valid_o / out_stall_i / out_data_o carries one result item
//   (status and value) for every request.
// - Each request reads one slot per cycle from the slot memory, starting at the
//   home slot, as the memory has a single read port. A request stops at a hit,
//   at an empty slot or after its last slot; its result then goes to the result
//   register, and the block takes the next item once it is back in idle. The
//   probe length is 1 to 1024 slots.
// - After reset the block sweeps the slot memory once to mark all slots empty,
//   with in_stall_o high.
// - The result register holds one finished item. A new request is accepted while
//   it waits; that request holds on its final slot until the receiver takes the
//   waiting result. Payload stays stable while out_stall_i is high.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  `include "assert_macros.svh"

  localparam int unsigned VB     = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int unsigned WORD_W = MARK_W + KEY_W + VB;

  state_e            state_q, state_d;
  logic [1:0]        func_q;
  logic [KEY_W-1:0]  key_q;
  logic [VB-1:0]     val_q;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic [IDX_W-1:0]  probe_q, probe_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q;

  logic              in_accept;
  logic              out_free;
  logic [IDX_W-1:0]  home;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [MARK_W-1:0] rd_mark;
  logic [KEY_W-1:0]  rd_key;
  logic [VB-1:0]     rd_value;
  logic              hit, empty, last, done, fin;
  logic              upd_we;
  logic [WORD_W-1:0] upd_word;
  status_e           rsp_status;
  logic [DATA_W-1:0] rsp_value;
  logic [CNT_W-1:0]  fin_count;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  lpht_hash u_hash (
    .key_lo_i (in_data_i.key[IDX_W-1:0]),
    .home_o   (home)
  );

  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign {rd_mark, rd_key, rd_value} = ram_rdata;

  assign hit   = (rd_mark == MK_USED) && (rd_key == key_q);
  assign empty = (rd_mark == MK_EMPTY);
  assign last  = (probe_q == IDX_W'(CAPACITY - 1));

  // Decide the result of the slot just read.
  always_comb begin
    upd_we     = 1'b0;
    upd_word   = {MK_USED, key_q, val_q};
    rsp_status = ST_NOT_FOUND;
    rsp_value  = '0;
    fin_count  = count_q;
    done       = 1'b1;
    case (func_q)
      FN_SET: begin
        if (hit) begin
          upd_we     = 1'b1;
          rsp_status = ST_UPDATED;
        end else if (empty) begin
          if (count_q >= CNT_W'(FULL_LIMIT)) begin
            rsp_status = ST_FULL;
          end else begin
            upd_we     = 1'b1;
            rsp_status = ST_INSERTED;
            fin_count  = count_q + CNT_W'(1);
          end
        end else begin
          rsp_status = ST_FULL;
          done       = last;
        end
      end
      FN_GET: begin
        if (hit) begin
          rsp_status = ST_FOUND;
          rsp_value  = DATA_W'(rd_value);
        end else begin
          done = empty || last;
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          upd_we     = 1'b1;
          upd_word   = {MK_DELETED, rd_key, rd_value};
          rsp_status = ST_REMOVED;
          if (count_q != '0) begin
            fin_count = count_q - CNT_W'(1);
          end
        end else begin
          done = empty || last;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign fin = (state_q == S_PROBE) && done && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (addr_q == IDX_W'(CAPACITY - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (fin) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Outputs of the sequencer: memory access, counters and result register.
  always_comb begin
    in_stall_o  = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = upd_word;
    ram_re      = 1'b0;
    ram_raddr   = addr_q + IDX_W'(1);
    addr_d      = addr_q;
    probe_d     = probe_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_d    = addr_q + IDX_W'(1);
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_accept;
        ram_raddr  = home;
        if (in_accept) begin
          addr_d  = home;
          probe_d = '0;
        end
      end
      S_PROBE: begin
        if (!done) begin
          // Advance to the next slot, wrapping at the end of the table.
          ram_re  = 1'b1;
          addr_d  = addr_q + IDX_W'(1);
          probe_d = probe_q + IDX_W'(1);
        end else if (fin) begin
          ram_we      = upd_we;
          count_d     = fin_count;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      probe_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      probe_q     <= probe_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= in_data_i.func;
      key_q  <= in_data_i.key;
      val_q  <= in_data_i.value_in[VB-1:0];
    end
    if (fin) begin
      out_q.status    <= rsp_status;
      out_q.value_out <= rsp_value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(FULL_LIMIT), "entry count above load limit")
  `ASSERT_IMPLY(a_fin_free, fin, !(out_valid_q && out_stall_i), "result overwrote waiting item")
  `ASSERT_IMPLY(a_no_write_idle, ram_we, state_q != S_IDLE, "slot write while idle")
  `ASSERT_NEXT(a_accept_probe, in_accept, state_q == S_PROBE, "accepted item did not start probing")

endmodule
